[rtl/cab_pkg.sv]
// shared types and constants for the crumple alpha blend pixel pipeline
package cab_pkg;

  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;

  // channel order inside an rgb_t
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

  localparam pix_t FULL = 8'd255;

  // bt.601 luma weights, 14 fractional bits, summing to 16384
  localparam int   LUMA_W     = 22;
  localparam int   LUMA_SHIFT = 14;
  localparam logic [LUMA_W-1:0] LUMA_R    = 22'd4899;
  localparam logic [LUMA_W-1:0] LUMA_G    = 22'd9617;
  localparam logic [LUMA_W-1:0] LUMA_B    = 22'd1868;
  localparam logic [LUMA_W-1:0] LUMA_HALF = 22'd8192;

  // crumple numerator c*nv + v/2 stays below 2^17
  localparam int NUM_W     = 17;
  localparam int DIV_STEPS = PIX_W;

  // x/255 as (x*32897) >> 23, exact for x below 66052
  localparam int MIX_W     = 17;
  localparam int MIX_PROD_W = 33;
  localparam int MIX_SHIFT = 23;
  localparam logic [MIX_PROD_W-1:0] MIX_RECIP = 33'd32897;
  localparam logic [MIX_W-1:0]      MIX_ROUND = 17'd127;

  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] num;
    pix_t val;
    pix_t alpha;
    rgb_t back;
  } div_req_t;

  typedef struct packed {
    rgb_t quo;
    pix_t val;
    pix_t alpha;
    rgb_t back;
  } div_rsp_t;

endpackage

[rtl/cab_in_if.sv]
// pixel input channel: fragment, alpha and background with valid/ready
interface cab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frag_blue;
  logic [7:0] frag_green;
  logic [7:0] frag_red;
  logic [7:0] frag_alpha;
  logic [7:0] back_blue;
  logic [7:0] back_green;
  logic [7:0] back_red;

  modport source (
    output valid, frag_blue, frag_green, frag_red, frag_alpha,
    output back_blue, back_green, back_red,
    input  ready
  );
  modport sink (
    input  valid, frag_blue, frag_green, frag_red, frag_alpha,
    input  back_blue, back_green, back_red,
    output ready
  );
endinterface

[rtl/cab_out_if.sv]
// pixel output channel: blended colour with valid/ready
interface cab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;

  modport source (
    output valid, out_blue, out_green, out_red,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red,
    output ready
  );
endinterface

[rtl/cab_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, three channels
module cab_div_pipe import cab_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  div_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output div_rsp_t out_rsp
);

  typedef struct packed {
    logic [NUM_CH-1:0][NUM_W-1:0] rem;
    rgb_t quo;
    pix_t val;
    pix_t alpha;
    rgb_t back;
  } step_t;

  step_t                st      [DIV_STEPS];
  step_t                st_in   [DIV_STEPS];
  step_t                st_next [DIV_STEPS];
  logic [DIV_STEPS-1:0] st_valid;
  logic [DIV_STEPS-1:0] vin;
  logic [DIV_STEPS-1:0] en;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en[DIV_STEPS-1] = !st_valid[DIV_STEPS-1] || out_ready;
    for (int s = DIV_STEPS-2; s >= 0; s--) begin
      en[s] = !st_valid[s] || en[s+1];
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    if (s == 0) begin : g_first
      always_comb begin
        st_in[s].rem   = in_req.num;
        st_in[s].quo   = '0;
        st_in[s].val   = in_req.val;
        st_in[s].alpha = in_req.alpha;
        st_in[s].back  = in_req.back;
      end
      assign vin[s] = in_valid;
    end else begin : g_rest
      assign st_in[s] = st[s-1];
      assign vin[s]   = st_valid[s-1];
    end

    // this stage decides quotient bit DIV_STEPS-1-s
    always_comb begin
      logic [NUM_W-1:0] dsh;
      logic             ge;
      st_next[s] = st_in[s];
      dsh = NUM_W'(st_in[s].val) << (DIV_STEPS-1-s);
      for (int c = 0; c < NUM_CH; c++) begin
        ge = st_in[s].rem[c] >= dsh;
        st_next[s].rem[c] = ge ? (st_in[s].rem[c] - dsh) : st_in[s].rem[c];
        st_next[s].quo[c] = {st_in[s].quo[c][PIX_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[s] <= 1'b0;
      end else if (en[s]) begin
        st_valid[s] <= vin[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = st_valid[DIV_STEPS-1];
  assign out_rsp.quo   = st[DIV_STEPS-1].quo;
  assign out_rsp.val   = st[DIV_STEPS-1].val;
  assign out_rsp.alpha = st[DIV_STEPS-1].alpha;
  assign out_rsp.back  = st[DIV_STEPS-1].back;

endmodule

[rtl/crumple_alpha_blend_pixel.sv]
// top level: crumple shading and alpha blend of one pixel per clock while not stalled
//
// Takes one pixel per clock while not stalled and gives one blended pixel per accepted pixel,
// in order. The fragment is first darkened by the relief of the background
// (255 minus its bt.601 luma): its value V, the largest channel, drops by
// the relief with a floor at zero, each channel is scaled by newV/V with
// rounding (black when V is zero), and the result is blended over the
// background as round((a*c + (255-a)*b)/255). Alpha zero gives the background
// unchanged. A pixel passes through three front stages (luma products and
// max, relief and new value, scaling numerators), eight stages of the
// divider that forms newV/V one quotient bit per stage, then the blend
// products and the output register that does the division by 255. Every
// stage has its own valid bit and moves whenever it is empty or the stage
// after it moves, so a new pixel is accepted every cycle unless a stalled
// output has filled the pipeline, and bubbles close up while the output is
// stalled. No state survives between pixels; reset only empties the pipeline.
module crumple_alpha_blend_pixel import cab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cab_in_if.sink     pix_in,
  cab_out_if.source  pix_out
);

  // stage a: luma partial products, fragment value
  logic              a_valid;
  rgb_t              a_frag;
  pix_t              a_alpha;
  rgb_t              a_back;
  pix_t              a_val;
  logic [LUMA_W-1:0] a_luma_r;
  logic [LUMA_W-1:0] a_luma_g;
  logic [LUMA_W-1:0] a_luma_b;

  // stage b: new value after relief
  logic b_valid;
  rgb_t b_frag;
  pix_t b_alpha;
  rgb_t b_back;
  pix_t b_val;
  pix_t b_nv;

  // stage c: divider request
  logic     c_valid;
  div_req_t c_req;

  // divider result
  logic     div_in_ready;
  logic     div_valid;
  div_rsp_t div_rsp;

  // stage d: blend sums before the divide by 255
  logic                        d_valid;
  logic [NUM_CH-1:0][MIX_W-1:0] d_x;

  // stage e: output register
  logic e_valid;
  rgb_t e_out;

  logic a_en;
  logic b_en;
  logic c_en;
  logic d_en;
  logic e_en;

  // ready chain from the output back to the input
  assign e_en = !e_valid || pix_out.ready;
  assign d_en = !d_valid || e_en;
  assign c_en = !c_valid || div_in_ready;
  assign b_en = !b_valid || c_en;
  assign a_en = !a_valid || b_en;

  assign pix_in.ready = a_en;

  // stage a inputs
  rgb_t in_frag;
  rgb_t in_back;
  pix_t in_val;

  always_comb begin
    in_frag[CH_BLUE]  = pix_in.frag_blue;
    in_frag[CH_GREEN] = pix_in.frag_green;
    in_frag[CH_RED]   = pix_in.frag_red;
    in_back[CH_BLUE]  = pix_in.back_blue;
    in_back[CH_GREEN] = pix_in.back_green;
    in_back[CH_RED]   = pix_in.back_red;
    in_val = in_frag[CH_BLUE];
    if (in_frag[CH_GREEN] > in_val) begin
      in_val = in_frag[CH_GREEN];
    end
    if (in_frag[CH_RED] > in_val) begin
      in_val = in_frag[CH_RED];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_frag   <= in_frag;
      a_alpha  <= pix_in.frag_alpha;
      a_back   <= in_back;
      a_val    <= in_val;
      a_luma_r <= LUMA_R * LUMA_W'(in_back[CH_RED]);
      a_luma_g <= LUMA_G * LUMA_W'(in_back[CH_GREEN]);
      a_luma_b <= LUMA_B * LUMA_W'(in_back[CH_BLUE]);
    end
  end

  // stage b: rounded luma never exceeds 255, so no clamp is needed
  logic [LUMA_W-1:0] luma_sum;
  pix_t              luma;
  pix_t              relief;
  pix_t              nv;

  always_comb begin
    luma_sum = a_luma_r + a_luma_g + a_luma_b + LUMA_HALF;
    luma     = luma_sum[LUMA_SHIFT +: PIX_W];
    relief   = FULL - luma;
    nv       = (a_val > relief) ? (a_val - relief) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_frag  <= a_frag;
      b_alpha <= a_alpha;
      b_back  <= a_back;
      b_val   <= a_val;
      b_nv    <= nv;
    end
  end

  // stage c: scaling numerators c*nv + v/2
  div_req_t req_next;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      req_next.num[c] = NUM_W'(b_frag[c]) * NUM_W'(b_nv) + NUM_W'(b_val >> 1);
    end
    req_next.val   = b_val;
    req_next.alpha = b_alpha;
    req_next.back  = b_back;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_req <= req_next;
    end
  end

  // newV/V per channel; quotient never exceeds newV, so 8 bits suffice
  cab_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (div_in_ready),
    .in_req    (c_req),
    .out_valid (div_valid),
    .out_ready (d_en),
    .out_rsp   (div_rsp)
  );

  // stage d: blend sums; a zero value forces a black fragment
  logic [NUM_CH-1:0][MIX_W-1:0] x_next;

  always_comb begin
    pix_t crumpled;
    for (int c = 0; c < NUM_CH; c++) begin
      crumpled  = (div_rsp.val == '0) ? '0 : div_rsp.quo[c];
      x_next[c] = MIX_W'(div_rsp.alpha) * MIX_W'(crumpled)
                + MIX_W'(FULL - div_rsp.alpha) * MIX_W'(div_rsp.back[c])
                + MIX_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_en) begin
      d_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_x <= x_next;
    end
  end

  // stage e: divide by 255 through the reciprocal multiply
  rgb_t out_next;

  always_comb begin
    logic [MIX_PROD_W-1:0] prod;
    for (int c = 0; c < NUM_CH; c++) begin
      prod        = MIX_PROD_W'(d_x[c]) * MIX_RECIP;
      out_next[c] = prod[MIX_SHIFT +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      e_out <= out_next;
    end
  end

  assign pix_out.valid     = e_valid;
  assign pix_out.out_blue  = e_out[CH_BLUE];
  assign pix_out.out_green = e_out[CH_GREEN];
  assign pix_out.out_red   = e_out[CH_RED];

endmodule

[verif/tb.sv]
// testbench for the crumple alpha blend pixel pipeline, self-checking against its own predictor
`timescale 1ns / 1ps

module tb;

  // bt.601 luma weights in 14 fractional bits, and the full-scale pixel value
  localparam int unsigned WEIGHT_RED   = 4899;
  localparam int unsigned WEIGHT_GREEN = 9617;
  localparam int unsigned WEIGHT_BLUE  = 1868;
  localparam int unsigned WEIGHT_HALF  = 8192;
  localparam int unsigned WEIGHT_SHIFT = 14;
  localparam int unsigned PIX_MAX      = 255;

  // one pixel as it goes into the block
  typedef struct packed {
    cab_pkg::pix_t frag_blue;
    cab_pkg::pix_t frag_green;
    cab_pkg::pix_t frag_red;
    cab_pkg::pix_t frag_alpha;
    cab_pkg::pix_t back_blue;
    cab_pkg::pix_t back_green;
    cab_pkg::pix_t back_red;
  } frag_pixel_t;

  // one blended pixel as it comes out
  typedef struct packed {
    cab_pkg::pix_t blue;
    cab_pkg::pix_t green;
    cab_pkg::pix_t red;
  } blend_pixel_t;

  // predicts every blended pixel and checks the block's results in order
  class blend_scoreboard;
    blend_pixel_t expected_pixels[$];
    int errors;
    int pixels_taken;
    int pixels_checked;
    int clear_pixels;
    int black_pixels;

    function new();
      errors = 0;
      pixels_taken = 0;
      pixels_checked = 0;
      clear_pixels = 0;
      black_pixels = 0;
    endfunction

    task report(string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    // channel scaled by newV/V, rounded half up, black when V is zero
    function int unsigned scale_chan(int unsigned c, int unsigned nv, int unsigned v);
      if (v == 0)
        return 0;
      return (c * nv + v / 2) / v;
    endfunction

    // round((a*f + (255-a)*b)/255)
    function int unsigned mix_chan(int unsigned a, int unsigned f, int unsigned b);
      return (a * f + (PIX_MAX - a) * b + 127) / PIX_MAX;
    endfunction

    function blend_pixel_t crumple_blend(frag_pixel_t p);
      blend_pixel_t res;
      int unsigned luma, relief, val, newval;
      if (p.frag_alpha == 0) begin
        clear_pixels++;
        res.blue  = p.back_blue;
        res.green = p.back_green;
        res.red   = p.back_red;
        return res;
      end
      luma = (WEIGHT_RED * p.back_red + WEIGHT_GREEN * p.back_green +
              WEIGHT_BLUE * p.back_blue + WEIGHT_HALF) >> WEIGHT_SHIFT;
      if (luma > PIX_MAX)
        luma = PIX_MAX;
      relief = PIX_MAX - luma;
      val = 32'(p.frag_blue);
      if (p.frag_green > val)
        val = 32'(p.frag_green);
      if (p.frag_red > val)
        val = 32'(p.frag_red);
      newval = (val > relief) ? val - relief : 0;
      if (newval == 0)
        black_pixels++;
      res.blue  = 8'(mix_chan(32'(p.frag_alpha),
                              scale_chan(32'(p.frag_blue), newval, val),
                              32'(p.back_blue)));
      res.green = 8'(mix_chan(32'(p.frag_alpha),
                              scale_chan(32'(p.frag_green), newval, val),
                              32'(p.back_green)));
      res.red   = 8'(mix_chan(32'(p.frag_alpha),
                              scale_chan(32'(p.frag_red), newval, val),
                              32'(p.back_red)));
      return res;
    endfunction

    function void note_input(frag_pixel_t p);
      pixels_taken++;
      expected_pixels.push_back(crumple_blend(p));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task check_result(cab_pkg::pix_t blue, cab_pkg::pix_t green, cab_pkg::pix_t red);
      blend_pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with nothing expected", blue, green, red));
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (blue !== want.blue)
        report($sformatf("pixel %0d blue %0d, want %0d", pixels_checked, blue, want.blue));
      if (green !== want.green)
        report($sformatf("pixel %0d green %0d, want %0d", pixels_checked, green, want.green));
      if (red !== want.red)
        report($sformatf("pixel %0d red %0d, want %0d", pixels_checked, red, want.red));
    endtask
  endclass

  logic clk;
  logic rst;

  cab_in_if  pix_in ();
  cab_out_if pix_out ();

  crumple_alpha_blend_pixel DUT (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .pix_out (pix_out.source)
  );

  blend_scoreboard board = new();

  // idling control: a calm side never idles, which gives stretches at full rate
  bit sender_calm;
  bit sink_calm;
  int stall_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_idle(bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side: ready drops for random stretches, changed on the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pix_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pix_out.ready <= 1'b1;
      stall_left <= pick_idle(sink_calm);
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready)
      board.check_result(pix_out.out_blue, pix_out.out_green, pix_out.out_red);
  end

  function automatic frag_pixel_t make_pixel(int fb, int fg, int fr, int a,
                                             int bb, int bg, int br);
    frag_pixel_t p;
    p.frag_blue  = 8'(fb);
    p.frag_green = 8'(fg);
    p.frag_red   = 8'(fr);
    p.frag_alpha = 8'(a);
    p.back_blue  = 8'(bb);
    p.back_green = 8'(bg);
    p.back_red   = 8'(br);
    return p;
  endfunction

  // random pixel shaped so that the crumpled fragment is often not plain black:
  // bright backgrounds give small relief, and alpha hits its ends often
  function automatic frag_pixel_t random_pixel();
    frag_pixel_t p;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      p.frag_alpha = 8'd0;
    else if (r < 4)
      p.frag_alpha = 8'd255;
    else if (r < 5)
      p.frag_alpha = 8'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(252, 254));
    else
      p.frag_alpha = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r < 6) begin
      p.back_blue  = 8'(255 - $urandom_range(0, 80));
      p.back_green = 8'(255 - $urandom_range(0, 80));
      p.back_red   = 8'(255 - $urandom_range(0, 80));
    end else begin
      p.back_blue  = 8'($urandom_range(0, 255));
      p.back_green = 8'($urandom_range(0, 255));
      p.back_red   = 8'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 9);
    if (r < 1) begin
      p.frag_blue  = 8'($urandom_range(0, 15));
      p.frag_green = 8'($urandom_range(0, 15));
      p.frag_red   = 8'($urandom_range(0, 15));
    end else begin
      p.frag_blue  = 8'($urandom_range(0, 255));
      p.frag_green = 8'($urandom_range(0, 255));
      p.frag_red   = 8'($urandom_range(0, 255));
      if (r < 3)
        p.frag_green = 8'd0;
    end
    return p;
  endfunction

  // one pixel transfer, preceded by a random gap with valid low
  task automatic send_pixel(frag_pixel_t p);
    int gap;
    gap = pick_idle(sender_calm);
    if (gap > 0) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_in.valid      <= 1'b1;
    pix_in.frag_blue  <= p.frag_blue;
    pix_in.frag_green <= p.frag_green;
    pix_in.frag_red   <= p.frag_red;
    pix_in.frag_alpha <= p.frag_alpha;
    pix_in.back_blue  <= p.back_blue;
    pix_in.back_green <= p.back_green;
    pix_in.back_red   <= p.back_red;
    do @(posedge clk); while (!pix_in.ready);
    board.note_input(p);
  endtask

  // stop sending and hold off until every predicted pixel has come out
  task automatic drain_pipeline();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst               = 1'b1;
    pix_in.valid      = 1'b0;
    pix_in.frag_blue  = '0;
    pix_in.frag_green = '0;
    pix_in.frag_red   = '0;
    pix_in.frag_alpha = '0;
    pix_in.back_blue  = '0;
    pix_in.back_green = '0;
    pix_in.back_red   = '0;
    pix_out.ready     = 1'b0;
    stall_left        = 0;
    sender_calm       = 1'b1;
    sink_calm         = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corners, sent back to back
    // clear fragment passes the background through
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(200, 17, 99, 0, 255, 255, 255));
    send_pixel(make_pixel(255, 255, 255, 0, 8'hA5, 8'h5A, 8'h3C));
    // white on white: no relief, opaque fragment comes through untouched
    send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255));
    // black background: full relief, crumpled fragment goes black
    send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0));
    // black fragment, value zero, no division
    send_pixel(make_pixel(0, 0, 0, 255, 128, 64, 32));
    send_pixel(make_pixel(0, 0, 0, 128, 255, 255, 255));
    // alpha just above zero and just below full
    send_pixel(make_pixel(0, 0, 255, 1, 255, 255, 255));
    send_pixel(make_pixel(255, 0, 0, 254, 240, 250, 245));
    // gray 200 background gives relief 55: value equal to it, then one above
    send_pixel(make_pixel(55, 20, 10, 255, 200, 200, 200));
    send_pixel(make_pixel(56, 30, 1, 255, 200, 200, 200));
    send_pixel(make_pixel(1, 56, 30, 170, 200, 200, 200));
    // value far above relief, each channel taking the maximum in turn
    send_pixel(make_pixel(255, 128, 1, 200, 255, 255, 255));
    send_pixel(make_pixel(3, 250, 100, 255, 250, 252, 251));
    send_pixel(make_pixel(7, 90, 251, 255, 245, 255, 250));
    // single-channel backgrounds probe each luma weight
    send_pixel(make_pixel(180, 200, 220, 255, 255, 0, 0));
    send_pixel(make_pixel(180, 200, 220, 255, 0, 255, 0));
    send_pixel(make_pixel(180, 200, 220, 255, 0, 0, 255));
    // smallest nonzero value on a white background
    send_pixel(make_pixel(1, 1, 1, 255, 255, 255, 255));
    send_pixel(make_pixel(1, 0, 0, 77, 255, 254, 253));
    // everything at its maximum, then a half-way alpha
    send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(255, 255, 255, 128, 0, 128, 255));
    drain_pipeline();

    // random part in phases that mix calm and idling sides
    for (int phase = 0; phase < 8; phase++) begin
      sender_calm = (phase == 0) || (phase == 1) || (phase == 5);
      sink_calm   = (phase == 0) || (phase == 2) || (phase == 6);
      for (int n = 0; n < 250; n++)
        send_pixel(random_pixel());
      // sender holds off once mid-run until the pipeline is empty
      if (phase == 3)
        drain_pipeline();
    end

    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    // linger a little past the pipeline depth to catch stray results
    repeat (30) @(posedge clk);

    $display("Sent %0d pixels and checked %0d blended results.",
             board.pixels_taken, board.pixels_checked);
    $display("Of these %0d were fully transparent and %0d crumpled to black.",
             board.clear_pixels, board.black_pixels);
    if (board.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // generous limit on the whole run
  initial begin
    #15_000_000;
    $display("Timeout: run did not finish.");
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/cab_pkg.sv
rtl/cab_in_if.sv
rtl/cab_out_if.sv
rtl/cab_div_pipe.sv
rtl/crumple_alpha_blend_pixel.sv
verif/tb.sv
